// ===== src/segint_pkg.sv =====
// shared constants for the segment intersection block
`timescale 1ns / 1ps
package segint_pkg;

    // width of each intersection coordinate on the result word
    localparam int POINT_W = 24;

    // fixed point value of one result coordinate
    typedef logic signed [POINT_W-1:0] t_point;

endpackage

// ===== src/segment_intersection.sv =====
// two-segment intersection test with fixed point crossing point
`timescale 1ns / 1ps
// Takes two segments A (a_start to a_end) and B (b_start to b_end) and reports whether
// they cross, with the crossing point A0 + t*(A1-A0) in signed fixed point with
// FRAC_BITS fraction bits, truncated toward zero and wrapped to 24 bits. Parallel or
// collinear segments never hit; on a miss both point coordinates read zero. The block
// takes one word per clock when not stalled, with no state between words: a new word can
// enter every cycle while earlier ones are still in flight, and a result held by a stalled
// output only backs up the pipeline as far as there are no empty slots to absorb it.
// Three stages form the differences, the six products and the cross products, one stage
// does the range test and magnitudes, then a bit-serial multiply-divide unrolled into one
// stage per bit of |A1-A0| << FRAC_BITS forms t*(A1-A0) exactly, and the last stage adds
// the start point, rounds toward zero and registers the result. No divider or wide
// multiplier sits in any stage; the widest single-cycle product is
// (COORD_WIDTH+1) x (COORD_WIDTH+1).
module segment_intersection #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input word
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_y,
    // result word
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output segint_pkg::t_point            o_point_x,
    output segint_pkg::t_point            o_point_y
);

    // widths derived from the coordinate width
    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;              // coordinate differences
    localparam int PW = 2 * DW;             // products, also magnitudes of den and nt
    localparam int NW = PW + 1;             // den, ns, nt
    localparam int MW = DW + FRAC_BITS;     // multiplier bits, one serial stage each
    localparam int QW = MW;                 // quotient magnitude
    localparam int RW = PW;                 // remainder, below |den|
    localparam int OW = W + FRAC_BITS + 3;  // signed point before wrapping
    localparam int XW = (OW > segint_pkg::POINT_W) ? OW : segint_pkg::POINT_W;

    // one restoring step of the multiply-divide: 2*(q*d + r) + b*nt, digit 0..2
    function automatic logic [QW+RW-1:0] f_step(
        input logic [QW-1:0] q,
        input logic [RW-1:0] r,
        input logic          b,
        input logic [RW-1:0] nt,
        input logic [RW-1:0] d
    );
        logic [RW+1:0] t;
        logic [RW+1:0] d1;
        logic [RW+1:0] d2;
        logic [1:0]    dig;
        t  = (RW+2)'({r, 1'b0}) + (b ? (RW+2)'(nt) : '0);
        d1 = (RW+2)'(d);
        d2 = (RW+2)'({d, 1'b0});
        priority if (t >= d2) begin
            t   = t - d2;
            dig = 2'd2;
        end else if (t >= d1) begin
            t   = t - d1;
            dig = 2'd1;
        end else begin
            dig = 2'd0;
        end
        return {QW'({q, 1'b0}) + QW'(dig), RW'(t)};
    endfunction

    // handshake enables, one per register stage, rippling back from the output
    logic          w_en_out;
    logic [MW:0]   w_en_s;
    logic          w_en3;
    logic          w_en2;
    logic          w_en1;

    // stage 1: sign-extended differences
    logic                 r_v1;
    logic signed [DW-1:0] r_dax, r_day, r_dbx, r_dby, r_ex, r_ey;
    logic signed [W-1:0]  r_ax1, r_ay1;

    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r_p_ab, r_p_ba, r_p_s0, r_p_s1, r_p_t0, r_p_t1;
    logic signed [DW-1:0] r_dax2, r_day2;
    logic signed [W-1:0]  r_ax2, r_ay2;

    // stage 3: denominator and the two numerators
    logic                 r_v3;
    logic signed [NW-1:0] r_den, r_ns, r_nt;
    logic signed [DW-1:0] r_dax3, r_day3;
    logic signed [W-1:0]  r_ax3, r_ay3;

    // serial multiply-divide stages; entry 0 holds the range test result
    logic                r_sv    [MW+1];
    logic                r_shit  [MW+1];
    logic                r_snegx [MW+1];
    logic                r_snegy [MW+1];
    logic signed [W-1:0] r_sax   [MW+1];
    logic signed [W-1:0] r_say   [MW+1];
    logic [RW-1:0]       r_smd   [MW+1];
    logic [RW-1:0]       r_smnt  [MW+1];
    logic [MW-1:0]       r_smx   [MW+1];
    logic [MW-1:0]       r_smy   [MW+1];
    logic [QW-1:0]       r_sqx   [MW+1];
    logic [RW-1:0]       r_srx   [MW+1];
    logic [QW-1:0]       r_sqy   [MW+1];
    logic [RW-1:0]       r_sry   [MW+1];

    // output register
    logic                r_ov;
    logic                r_hit;
    segint_pkg::t_point  r_px, r_py;

    // a stage moves when it is empty or the stage after it moves
    always_comb begin
        w_en_out   = !r_ov || !i_stall;
        w_en_s[MW] = !r_sv[MW] || w_en_out;
        for (int k = MW - 1; k >= 0; k--) begin
            w_en_s[k] = !r_sv[k] || w_en_s[k+1];
        end
        w_en3 = !r_v3 || w_en_s[0];
        w_en2 = !r_v2 || w_en3;
        w_en1 = !r_v1 || w_en2;
    end

    assign o_stall = !w_en1;

    // stage 1: direction vectors and B0 - A0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_valid;
        end
        if (w_en1) begin
            r_dax <= DW'(i_a_end_x) - DW'(i_a_start_x);
            r_day <= DW'(i_a_end_y) - DW'(i_a_start_y);
            r_dbx <= DW'(i_b_end_x) - DW'(i_b_start_x);
            r_dby <= DW'(i_b_end_y) - DW'(i_b_start_y);
            r_ex  <= DW'(i_b_start_x) - DW'(i_a_start_x);
            r_ey  <= DW'(i_b_start_y) - DW'(i_a_start_y);
            r_ax1 <= i_a_start_x;
            r_ay1 <= i_a_start_y;
        end
    end

    // stage 2: the six cross-product terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
        if (w_en2) begin
            r_p_ab <= PW'(r_dax) * PW'(r_dby);
            r_p_ba <= PW'(r_dbx) * PW'(r_day);
            r_p_s0 <= PW'(r_day) * PW'(r_ex);
            r_p_s1 <= PW'(r_dax) * PW'(r_ey);
            r_p_t0 <= PW'(r_dby) * PW'(r_ex);
            r_p_t1 <= PW'(r_dbx) * PW'(r_ey);
            r_dax2 <= r_dax;
            r_day2 <= r_day;
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
        end
    end

    // stage 3: den = dA x dB, ns, nt
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= r_v2;
        end
        if (w_en3) begin
            r_den  <= NW'(r_p_ab) - NW'(r_p_ba);
            r_ns   <= NW'(r_p_s0) - NW'(r_p_s1);
            r_nt   <= NW'(r_p_t0) - NW'(r_p_t1);
            r_dax3 <= r_dax2;
            r_day3 <= r_day2;
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;
        end
    end

    // range test on signs and magnitudes, no division
    logic [NW-1:0] w_mden, w_mns, w_mnt;
    logic [DW-1:0] w_mdx, w_mdy;
    logic          w_ok_s, w_ok_t, w_hit;

    always_comb begin
        w_mden = r_den[NW-1] ? NW'(-r_den) : NW'(r_den);
        w_mns  = r_ns[NW-1]  ? NW'(-r_ns)  : NW'(r_ns);
        w_mnt  = r_nt[NW-1]  ? NW'(-r_nt)  : NW'(r_nt);
        w_mdx  = r_dax3[DW-1] ? DW'(-r_dax3) : DW'(r_dax3);
        w_mdy  = r_day3[DW-1] ? DW'(-r_day3) : DW'(r_day3);
        w_ok_s = !((r_ns != '0) && (r_ns[NW-1] != r_den[NW-1])) && (w_mns <= w_mden);
        w_ok_t = !((r_nt != '0) && (r_nt[NW-1] != r_den[NW-1])) && (w_mnt <= w_mden);
        w_hit  = (r_den != '0) && w_ok_s && w_ok_t;
    end

    // stage 4: load the serial unit with zero quotient and remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_en_s[0]) begin
            r_sv[0] <= r_v3;
        end
        if (w_en_s[0]) begin
            r_shit[0]  <= w_hit;
            // sign of t*dA; den and nt agree in sign on a hit
            r_snegx[0] <= r_nt[NW-1] ^ r_den[NW-1] ^ r_dax3[DW-1];
            r_snegy[0] <= r_nt[NW-1] ^ r_den[NW-1] ^ r_day3[DW-1];
            r_sax[0]   <= r_ax3;
            r_say[0]   <= r_ay3;
            r_smd[0]   <= RW'(w_mden);
            r_smnt[0]  <= RW'(w_mnt);
            r_smx[0]   <= MW'(w_mdx) << FRAC_BITS;
            r_smy[0]   <= MW'(w_mdy) << FRAC_BITS;
            r_sqx[0]   <= '0;
            r_srx[0]   <= '0;
            r_sqy[0]   <= '0;
            r_sry[0]   <= '0;
        end
    end

    // multiply-divide: stage j takes multiplier bit MW-j, msb first
    for (genvar j = 1; j <= MW; j++) begin : g_serial
        logic [QW+RW-1:0] w_nx, w_ny;

        assign w_nx = f_step(r_sqx[j-1], r_srx[j-1], r_smx[j-1][MW-j],
                             r_smnt[j-1], r_smd[j-1]);
        assign w_ny = f_step(r_sqy[j-1], r_sry[j-1], r_smy[j-1][MW-j],
                             r_smnt[j-1], r_smd[j-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (w_en_s[j]) begin
                r_sv[j] <= r_sv[j-1];
            end
            if (w_en_s[j]) begin
                r_shit[j]  <= r_shit[j-1];
                r_snegx[j] <= r_snegx[j-1];
                r_snegy[j] <= r_snegy[j-1];
                r_sax[j]   <= r_sax[j-1];
                r_say[j]   <= r_say[j-1];
                r_smd[j]   <= r_smd[j-1];
                r_smnt[j]  <= r_smnt[j-1];
                r_smx[j]   <= r_smx[j-1];
                r_smy[j]   <= r_smy[j-1];
                r_sqx[j]   <= w_nx[QW+RW-1:RW];
                r_srx[j]   <= w_nx[RW-1:0];
                r_sqy[j]   <= w_ny[QW+RW-1:RW];
                r_sry[j]   <= w_ny[RW-1:0];
            end
        end
    end

    // add the start point and truncate toward zero:
    // the exact value is base + sign*(q + r/|den|); floor first, then step up if negative
    logic signed [OW-1:0] w_bx, w_by, w_kx, w_ky, w_resx, w_resy;
    logic signed [XW-1:0] w_extx, w_exty;
    logic                 w_fx, w_fy;

    always_comb begin
        w_fx = r_srx[MW] != '0;
        w_fy = r_sry[MW] != '0;
        w_bx = OW'(r_sax[MW]) <<< FRAC_BITS;
        w_by = OW'(r_say[MW]) <<< FRAC_BITS;
        if (r_snegx[MW]) begin
            w_kx = w_bx - signed'(OW'(r_sqx[MW])) - signed'(OW'(w_fx));
        end else begin
            w_kx = w_bx + signed'(OW'(r_sqx[MW]));
        end
        if (r_snegy[MW]) begin
            w_ky = w_by - signed'(OW'(r_sqy[MW])) - signed'(OW'(w_fy));
        end else begin
            w_ky = w_by + signed'(OW'(r_sqy[MW]));
        end
        w_resx = (w_fx && w_kx[OW-1]) ? w_kx + OW'(1) : w_kx;
        w_resy = (w_fy && w_ky[OW-1]) ? w_ky + OW'(1) : w_ky;
        w_extx = XW'(w_resx);
        w_exty = XW'(w_resy);
    end

    // output register; a miss reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en_out) begin
            r_ov <= r_sv[MW];
        end
        if (w_en_out) begin
            r_hit <= r_shit[MW];
            r_px  <= r_shit[MW] ? w_extx[segint_pkg::POINT_W-1:0] : '0;
            r_py  <= r_shit[MW] ? w_exty[segint_pkg::POINT_W-1:0] : '0;
        end
    end

    assign o_valid   = r_ov;
    assign o_hit     = r_hit;
    assign o_point_x = r_px;
    assign o_point_y = r_py;

endmodule

// ===== src/segint_checker.sv =====
// port-level checks for the segment intersection block, bound to the top level
`timescale 1ns / 1ps
module segint_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_stall,
    input logic               o_stall,
    input logic               o_valid,
    input logic               o_hit,
    input segint_pkg::t_point o_point_x,
    input segint_pkg::t_point o_point_y
);

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_point_x == '0 && o_point_y == '0))
        else $error("miss with nonzero point");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // input backs up only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with output free");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit)
            && $stable(o_point_x) && $stable(o_point_y)))
        else $error("held result changed");

endmodule

bind segment_intersection segint_checker u_segint_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_stall   (i_stall),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .o_hit     (o_hit),
    .o_point_x (o_point_x),
    .o_point_y (o_point_y)
);

// ===== tb/segment_intersection_tb.sv =====
// self-checking testbench for the segment intersection block
`timescale 1ns / 1ps
module segment_intersection_tb;

    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 8;
    localparam int RAND_WORDS = 1400;
    // extra wait after the expectation queue empties
    localparam int DRAIN_CYCLES = 60;
    localparam int NUM_ROWS = 20;

    // one input word: two segments, each from start to end
    typedef struct {
        logic signed [COORD_W-1:0] a_start_x;
        logic signed [COORD_W-1:0] a_start_y;
        logic signed [COORD_W-1:0] a_end_x;
        logic signed [COORD_W-1:0] a_end_y;
        logic signed [COORD_W-1:0] b_start_x;
        logic signed [COORD_W-1:0] b_start_y;
        logic signed [COORD_W-1:0] b_end_x;
        logic signed [COORD_W-1:0] b_end_y;
    } t_seg_pair;

    // one result word
    typedef struct {
        logic               hit;
        segint_pkg::t_point point_x;
        segint_pkg::t_point point_y;
    } t_crossing;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_a_start_x;
    logic signed [COORD_W-1:0] i_a_start_y;
    logic signed [COORD_W-1:0] i_a_end_x;
    logic signed [COORD_W-1:0] i_a_end_y;
    logic signed [COORD_W-1:0] i_b_start_x;
    logic signed [COORD_W-1:0] i_b_start_y;
    logic signed [COORD_W-1:0] i_b_end_x;
    logic signed [COORD_W-1:0] i_b_end_y;
    logic                      o_valid;
    logic                      i_stall;
    logic                      o_hit;
    segint_pkg::t_point        o_point_x;
    segint_pkg::t_point        o_point_y;

    // expected crossing that travels with the word on the input pins
    t_crossing   cur_expect;
    t_crossing   crossing_q [$];
    int unsigned mismatches;

    // directed words: a start xy, a end xy, b start xy, b end xy,
    // then typed flag, hit, point x, point y (fixed point, 8 fraction bits)
    int dir_tab [NUM_ROWS][12] = '{
        // everything zero: degenerate, parallel
        '{0, 0, 0, 0, 0, 0, 0, 0,                 1, 0, 0, 0},
        // plain cross at (5,0)
        '{0, 0, 10, 0, 5, -5, 5, 5,               1, 1, 1280, 0},
        // a ends where b starts
        '{0, 0, 10, 10, 10, 10, 20, 0,            1, 1, 2560, 2560},
        // parallel with an offset
        '{0, 0, 10, 0, 0, 5, 10, 5,               1, 0, 0, 0},
        // collinear and overlapping, still parallel
        '{0, 0, 10, 0, 5, 0, 15, 0,               1, 0, 0, 0},
        // b one pixel past the end of a
        '{0, 0, 10, 0, 11, -5, 11, 5,             1, 0, 0, 0},
        // b stops short of a
        '{0, 0, 10, 0, 5, 1, 5, 5,                1, 0, 0, 0},
        // full range diagonals, cross at (-0.5,-0.5)
        '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                                                  1, 1, -128, -128},
        // edges meeting at the most negative corner
        '{-32768, -32768, 32767, -32768, -32768, -32768, -32768, 32767,
                                                  1, 1, -8388608, -8388608},
        // edges meeting at the most positive corner
        '{32767, 32767, -32768, 32767, 32767, -32768, 32767, 32767,
                                                  1, 1, 8388352, 8388352},
        // fractional x, truncated toward zero
        '{0, 0, 3, 0, 1, -1, 2, 2,                0, 0, 0, 0},
        // mirrored: negative fractional x
        '{0, 0, -3, 0, -1, -1, -2, 2,             0, 0, 0, 0},
        // negative fractional y
        '{0, 0, 0, -3, -1, -1, 2, -2,             0, 0, 0, 0},
        // plain cross with both segments reversed
        '{10, 0, 0, 0, 5, 5, 5, -5,               1, 1, 1280, 0},
        // a shrunk to a point on b
        '{5, 0, 5, 0, 0, 0, 10, 0,                1, 0, 0, 0},
        // b starts on the inside of a
        '{0, 0, 10, 0, 4, 0, 4, 7,                1, 1, 1024, 0},
        // long nearly axis aligned segments, fractional point
        '{-32768, 0, 32767, 1, 0, -32768, 1, 32767, 0, 0, 0, 0},
        // all coordinates at the top of the range
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                                  1, 0, 0, 0},
        // all coordinates minus one, every bit set
        '{-1, -1, -1, -1, -1, -1, -1, -1,         1, 0, 0, 0},
        // alternating bit patterns
        '{21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845,
                                                  0, 0, 0, 0}
    };

    segment_intersection #(
        .COORD_WIDTH (COORD_W),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // num/den inside [0,1], decided by signs and magnitudes; den is nonzero
    function automatic bit frac_in_unit(longint num, longint den);
        longint num_mag;
        longint den_mag;
        num_mag = (num < 0) ? -num : num;
        den_mag = (den < 0) ? -den : den;
        if (num != 0 && ((num < 0) != (den < 0)))
            return 1'b0;
        return num_mag <= den_mag;
    endfunction

    // exact crossing of the two segments; every intermediate stays below 2^59,
    // so 64-bit arithmetic is enough and the division truncates toward zero
    function automatic t_crossing predict_crossing(t_seg_pair p);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint dax, day, dbx, dby;
        longint den, ns, nt, qx, qy;
        t_crossing r;
        ax0 = p.a_start_x;
        ay0 = p.a_start_y;
        ax1 = p.a_end_x;
        ay1 = p.a_end_y;
        bx0 = p.b_start_x;
        by0 = p.b_start_y;
        bx1 = p.b_end_x;
        by1 = p.b_end_y;
        dax = ax1 - ax0;
        day = ay1 - ay0;
        dbx = bx1 - bx0;
        dby = by1 - by0;
        den = dax * dby - dbx * day;
        ns  = day * (bx0 - ax0) - dax * (by0 - ay0);
        nt  = dbx * (ay0 - by0) - dby * (ax0 - bx0);
        r.hit     = 1'b0;
        r.point_x = '0;
        r.point_y = '0;
        // parallel or collinear never hits; a miss leaves the point at zero
        if (den != 0 && frac_in_unit(ns, den) && frac_in_unit(nt, den)) begin
            qx = ((ax0 * den + nt * dax) <<< FRAC_BITS) / den;
            qy = ((ay0 * den + nt * day) <<< FRAC_BITS) / den;
            r.hit     = 1'b1;
            r.point_x = qx[segint_pkg::POINT_W-1:0];
            r.point_y = qy[segint_pkg::POINT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_coord();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] near(int center, int span);
        int v;
        v = center + $urandom_range(0, 2 * span) - span;
        return v[COORD_W-1:0];
    endfunction

    // random pair, weighted toward shapes that reach the range test and the divide
    function automatic t_seg_pair random_pair();
        t_seg_pair p;
        int cx, cy, span, ux, uy, vx, vy, ox, oy;
        int kind;
        kind = $urandom_range(0, 9);
        span = 4 << (3 * $urandom_range(0, 3));  // 4, 32, 256 or 2048
        cx   = $urandom_range(0, 58000) - 29000;
        cy   = $urandom_range(0, 58000) - 29000;
        {p.a_start_x, p.a_start_y, p.a_end_x, p.a_end_y} = {$urandom, $urandom};
        {p.b_start_x, p.b_start_y, p.b_end_x, p.b_end_y} = {$urandom, $urandom};
        if (kind < 3) begin
            // full range noise
        end else if (kind < 6) begin
            // all endpoints in one small cluster: frequent hits, fractional points
            if (span > 1024) span = 1024;
            p.a_start_x = near(cx, span);
            p.a_start_y = near(cy, span);
            p.a_end_x   = near(cx, span);
            p.a_end_y   = near(cy, span);
            p.b_start_x = near(cx, span);
            p.b_start_y = near(cy, span);
            p.b_end_x   = near(cx, span);
            p.b_end_y   = near(cy, span);
        end else if (kind == 6) begin
            // both segments pass through one common point
            if (span > 1024) span = 1024;
            ux = $urandom_range(0, 2 * span) - span;
            uy = $urandom_range(0, 2 * span) - span;
            vx = $urandom_range(0, 2 * span) - span;
            vy = $urandom_range(0, 2 * span) - span;
            p.a_start_x = COORD_W'(cx + ux);
            p.a_start_y = COORD_W'(cy + uy);
            p.a_end_x   = COORD_W'(cx - $urandom_range(1, 3) * ux);
            p.a_end_y   = COORD_W'(cy - $urandom_range(1, 3) * uy);
            p.b_start_x = COORD_W'(cx + vx);
            p.b_start_y = COORD_W'(cy + vy);
            p.b_end_x   = COORD_W'(cx - $urandom_range(1, 3) * vx);
            p.b_end_y   = COORD_W'(cy - $urandom_range(1, 3) * vy);
        end else if (kind == 7) begin
            // b is a shifted copy of a, parallel or collinear
            ox = $urandom_range(0, 2 * span) - span;
            oy = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 2 * span) - span;
            p.a_start_x = near(cx, span);
            p.a_start_y = near(cy, span);
            p.a_end_x   = near(cx, span);
            p.a_end_y   = near(cy, span);
            p.b_start_x = COORD_W'(p.a_start_x + ox);
            p.b_start_y = COORD_W'(p.a_start_y + oy);
            p.b_end_x   = COORD_W'(p.a_end_x + ox);
            p.b_end_y   = COORD_W'(p.a_end_y + oy);
        end else if (kind == 8) begin
            // shared endpoint, t or s at exactly zero or one
            if ($urandom_range(0, 1) == 0) begin
                p.b_start_x = p.a_end_x;
                p.b_start_y = p.a_end_y;
            end else begin
                p.b_end_x = p.a_start_x;
                p.b_end_y = p.a_start_y;
            end
        end else begin
            // range extremes in every field
            p.a_start_x = edge_coord();
            p.a_start_y = edge_coord();
            p.a_end_x   = edge_coord();
            p.a_end_y   = edge_coord();
            p.b_start_x = edge_coord();
            p.b_start_y = edge_coord();
            p.b_end_x   = edge_coord();
            p.b_end_y   = edge_coord();
        end
        return p;
    endfunction

    task automatic put_pins(t_seg_pair p);
        i_a_start_x <= p.a_start_x;
        i_a_start_y <= p.a_start_y;
        i_a_end_x   <= p.a_end_x;
        i_a_end_y   <= p.a_end_y;
        i_b_start_x <= p.b_start_x;
        i_b_start_y <= p.b_start_y;
        i_b_end_x   <= p.b_end_x;
        i_b_end_y   <= p.b_end_y;
    endtask

    // present one word and hold it until the edge that accepts it
    task automatic send_word(t_seg_pair p, t_crossing want);
        put_pins(p);
        cur_expect <= want;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid for as long as the cycles argument says; the idle payload is junk
    task automatic idle_for(int cycles);
        i_valid <= 1'b0;
        put_pins(random_pair());
        repeat (cycles) @(posedge i_clk);
    endtask

    // sender: reset, directed table, then random words in bursts
    initial begin : stimulus
        t_seg_pair p;
        t_crossing want;
        int        burst_left;
        bit        no_gaps;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        cur_expect <= '{hit: 1'b0, point_x: '0, point_y: '0};
        put_pins('{default: '0});
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            p.a_start_x = dir_tab[r][0][COORD_W-1:0];
            p.a_start_y = dir_tab[r][1][COORD_W-1:0];
            p.a_end_x   = dir_tab[r][2][COORD_W-1:0];
            p.a_end_y   = dir_tab[r][3][COORD_W-1:0];
            p.b_start_x = dir_tab[r][4][COORD_W-1:0];
            p.b_start_y = dir_tab[r][5][COORD_W-1:0];
            p.b_end_x   = dir_tab[r][6][COORD_W-1:0];
            p.b_end_y   = dir_tab[r][7][COORD_W-1:0];
            if (dir_tab[r][8] != 0) begin
                want.hit     = dir_tab[r][9][0];
                want.point_x = dir_tab[r][10][segint_pkg::POINT_W-1:0];
                want.point_y = dir_tab[r][11][segint_pkg::POINT_W-1:0];
            end else begin
                want = predict_crossing(p);
            end
            send_word(p, want);
            if ($urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 3));
        end

        // random part: bursts with gaps, and every 256 words a random draw decides
        // whether the next stretch runs back to back
        burst_left = 0;
        no_gaps    = 1'b0;
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 256 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if (burst_left == 0) begin
                if (!no_gaps)
                    idle_for($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            p = random_pair();
            send_word(p, predict_crossing(p));
        end
        i_valid <= 1'b0;

        while (crossing_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && crossing_q.size() == 0)
            $display("segment_intersection test passed");
        else
            $display("segment_intersection test failed");
        $finish;
    end

    // receiver stall pattern: free, light, heavy or periodic, with the mode
    // redrawn at random whenever its countdown runs out
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned stall_phase;
    int unsigned stall_period;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            stall_mode   <= 0;
            mode_left    <= 100;
            stall_phase  <= 0;
            stall_period <= 4;
        end else begin
            if (mode_left == 0) begin
                stall_mode   <= $urandom_range(0, 3);
                mode_left    <= $urandom_range(50, 400);
                stall_period <= $urandom_range(2, 9);
                stall_phase  <= 0;
            end else begin
                mode_left   <= mode_left - 1;
                stall_phase <= (stall_phase + 1 >= stall_period) ? 0 : stall_phase + 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 7) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (stall_phase == 0);
            endcase
        end
    end

    // scoreboard: retire a result word against the oldest expectation, then
    // queue the expectation of the word accepted at this same edge
    always @(posedge i_clk) begin : scoreboard
        t_crossing want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (crossing_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with nothing expected: hit %0b x %0d y %0d",
                                 o_hit, o_point_x, o_point_y);
                end else begin
                    want = crossing_q.pop_front();
                    if (o_hit !== want.hit || o_point_x !== want.point_x ||
                            o_point_y !== want.point_y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected hit %0b x %0d y %0d, got hit %0b x %0d y %0d",
                                     want.hit, want.point_x, want.point_y,
                                     o_hit, o_point_x, o_point_y);
                    end
                end
            end
            if (i_valid && !o_stall)
                crossing_q.push_back(cur_expect);
        end
    end

    initial mismatches = 0;

    // watchdog far beyond the slowest correct run
    initial begin
        #5000000;
        $display("segment_intersection test failed");
        $finish;
    end

endmodule
